### rtl/dpfifo_pkg.sv
`timescale 1ns / 1ps
package dpfifo_pkg;

    localparam int SRC_W   = 20;
    localparam int DST_W   = 20;
    localparam int TS_W    = 30;
    localparam int OP_W    = 2;
    localparam int CAP_W   = 9;
    localparam int WCNT_W  = 9;

    localparam int DEPTH_DEF = 256;
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_FWD   = 2'd1,
        OP_COUNT = 2'd2
    } t_opcode;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [SRC_W-1:0] source;
        logic [DST_W-1:0] destination;
        logic [TS_W-1:0]  timestamp;
        logic [TS_W-1:0]  start_time;
        logic [TS_W-1:0]  end_time;
    } t_in_item;

    typedef struct packed {
        logic              accepted;
        logic              packet_valid;
        logic [SRC_W-1:0]  out_source;
        logic [DST_W-1:0]  out_destination;
        logic [TS_W-1:0]   out_timestamp;
        logic [WCNT_W-1:0] window_count;
    } t_out_item;

    typedef struct packed {
        logic [SRC_W-1:0] source;
        logic [DST_W-1:0] destination;
        logic [TS_W-1:0]  timestamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic clear;
        logic cmp_en;
        logic mode_add;
    } t_scan_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FWD_RD,
        ST_DECIDE,
        ST_RESULT
    } t_state;

endpackage

### rtl/dpfifo_if.sv
`timescale 1ns / 1ps
interface dpfifo_in_if;
    import dpfifo_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dpfifo_out_if;
    import dpfifo_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dpfifo_cfg_if;
    import dpfifo_pkg::*;
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/dpfifo_ram.sv
`timescale 1ns / 1ps
module dpfifo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

### rtl/dpfifo_scan.sv
`timescale 1ns / 1ps
module dpfifo_scan #(
    parameter int DEPTH = dpfifo_pkg::DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dpfifo_pkg::t_scan_ctl      i_ctl,
    input  dpfifo_pkg::t_in_item       i_key,
    input  dpfifo_pkg::t_entry         i_entry,
    output logic                       o_dup,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    import dpfifo_pkg::*;

    localparam int OCC_W = $clog2(DEPTH+1);

    logic             r_dup;
    logic             n_dup;
    logic [OCC_W-1:0] r_count;
    logic [OCC_W-1:0] n_count;
    logic             dst_eq;
    logic             hit_add;
    logic             hit_cnt;

    // One comparator set, shared by the duplicate check and the window count.
    always_comb begin
        dst_eq  = (i_entry.destination == i_key.destination);
        hit_add = dst_eq && (i_entry.source == i_key.source)
                  && (i_entry.timestamp == i_key.timestamp);
        hit_cnt = dst_eq && (i_entry.timestamp >= i_key.start_time)
                  && (i_entry.timestamp <= i_key.end_time);
    end

    always_comb begin
        n_dup   = r_dup;
        n_count = r_count;
        if (i_ctl.clear) begin
            n_dup   = 1'b0;
            n_count = '0;
        end else if (i_ctl.cmp_en) begin
            if (i_ctl.mode_add) begin
                n_dup = r_dup | hit_add;
            end else if (hit_cnt) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dup   <= 1'b0;
            r_count <= '0;
        end else begin
            r_dup   <= n_dup;
            r_count <= n_count;
        end
    end

    assign o_dup   = r_dup;
    assign o_count = r_count;
endmodule

### rtl/dedup_packet_fifo_with_window_count_unit.sv
`timescale 1ns / 1ps
// Bounded packet FIFO with a duplicate filter and a window count. Each beat on
// i_item is one command: add, forward or count (an unused opcode gives an empty
// result); each produces exactly one beat on o_result. Records live in a
// single-port-read RAM, and add and count walk every held record through one
// shared comparator, one record per cycle. i_item is not ready while a command
// is in progress; a finished result waits in the output register. The capacity
// port is ready only while no command is in progress, and a new capacity takes
// effect on the next add. The store needs no clearing after reset.
module dedup_packet_fifo_with_window_count_unit #(
    parameter int DEPTH = dpfifo_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dpfifo_cfg_if.sink    i_cfg,
    dpfifo_in_if.sink     i_item,
    dpfifo_out_if.source  o_result
);
    import dpfifo_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH+1);
    localparam int CW    = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam logic [AW-1:0]    LAST_SLOT = AW'(DEPTH-1);
    localparam logic [CW-1:0]    DEPTH_C   = CW'(DEPTH);
    localparam logic [OCC_W-1:0] DEPTH_OCC = OCC_W'(DEPTH);

    t_state           r_state;
    t_state           n_state;
    t_in_item         r_item;
    t_in_item         n_item;
    logic [AW-1:0]    r_head;
    logic [AW-1:0]    n_head;
    logic [AW-1:0]    r_tail;
    logic [AW-1:0]    n_tail;
    logic [OCC_W-1:0] r_occ;
    logic [OCC_W-1:0] n_occ;
    logic [OCC_W-1:0] r_k;
    logic [OCC_W-1:0] n_k;
    logic [AW-1:0]    r_scan_addr;
    logic [AW-1:0]    n_scan_addr;
    logic             r_rd_vld;
    logic             n_rd_vld;
    logic [CAP_W-1:0] r_cap;
    logic [CAP_W-1:0] n_cap;
    t_out_item        r_res;
    t_out_item        n_res;
    logic             r_out_vld;
    logic             n_out_vld;
    t_out_item        r_out;
    t_out_item        n_out;

    logic             accept_in;
    logic             out_take;
    logic [CW-1:0]    cap_ext;
    logic [CW-1:0]    eff_cap;
    logic             must_drop;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    t_entry           wr_data;
    t_entry           rd_data;
    t_scan_ctl        scan_ctl;
    logic             scan_dup;
    logic [OCC_W-1:0] scan_count;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
        next_slot = (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    assign accept_in      = i_item.valid && i_item.ready;
    assign out_take       = o_result.valid && o_result.ready;
    assign i_item.ready   = (r_state == ST_IDLE);
    assign i_cfg.ready    = (r_state == ST_IDLE);
    assign o_result.valid = r_out_vld;
    assign o_result.data  = r_out;

    // A capacity of zero acts as one; anything above the store size saturates.
    always_comb begin
        cap_ext = CW'(r_cap);
        if (cap_ext == '0) begin
            eff_cap = CW'(1);
        end else if (cap_ext > DEPTH_C) begin
            eff_cap = DEPTH_C;
        end else begin
            eff_cap = cap_ext;
        end
        must_drop = (CW'(r_occ) >= eff_cap) && (r_occ != '0);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept_in) begin
                    case (i_item.data.opcode)
                        OP_ADD:   n_state = ST_SCAN;
                        OP_COUNT: n_state = ST_SCAN;
                        OP_FWD:   n_state = ST_FWD_RD;
                        default:  n_state = ST_DECIDE;
                    endcase
                end
            end
            ST_SCAN: begin
                if ((r_k == r_occ) && !r_rd_vld) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_FWD_RD: n_state = ST_DECIDE;
            ST_DECIDE: n_state = ST_RESULT;
            ST_RESULT: begin
                if (!r_out_vld || o_result.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_item      = r_item;
        n_head      = r_head;
        n_tail      = r_tail;
        n_occ       = r_occ;
        n_k         = r_k;
        n_scan_addr = r_scan_addr;
        n_rd_vld    = 1'b0;
        n_res       = r_res;
        n_out       = r_out;
        n_out_vld   = r_out_vld && !out_take;
        n_cap       = (i_cfg.valid && i_cfg.ready) ? i_cfg.data : r_cap;
        rd_en       = 1'b0;
        rd_addr     = r_head;
        wr_en       = 1'b0;
        wr_addr     = r_tail;
        wr_data     = '{source: r_item.source, destination: r_item.destination,
                        timestamp: r_item.timestamp};
        scan_ctl    = '{clear: 1'b0, cmp_en: 1'b0,
                        mode_add: (r_item.opcode == OP_ADD)};
        case (r_state)
            ST_IDLE: begin
                if (accept_in) begin
                    n_item         = i_item.data;
                    n_k            = '0;
                    n_scan_addr    = r_head;
                    scan_ctl.clear = 1'b1;
                end
            end
            ST_SCAN: begin
                // Read data arrives in the cycle after the address is issued.
                scan_ctl.cmp_en = r_rd_vld;
                if (r_k != r_occ) begin
                    rd_en       = 1'b1;
                    rd_addr     = r_scan_addr;
                    n_scan_addr = next_slot(r_scan_addr);
                    n_k         = r_k + 1'b1;
                    n_rd_vld    = 1'b1;
                end
            end
            ST_FWD_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_head;
            end
            ST_DECIDE: begin
                n_res = '0;
                case (r_item.opcode)
                    OP_ADD: begin
                        if (!scan_dup) begin
                            wr_en  = 1'b1;
                            n_tail = next_slot(r_tail);
                            if (must_drop) begin
                                n_head = next_slot(r_head);
                            end else begin
                                n_occ = r_occ + 1'b1;
                            end
                            n_res.accepted = 1'b1;
                        end
                    end
                    OP_FWD: begin
                        if (r_occ != '0) begin
                            n_res.packet_valid    = 1'b1;
                            n_res.out_source      = rd_data.source;
                            n_res.out_destination = rd_data.destination;
                            n_res.out_timestamp   = rd_data.timestamp;
                            n_head                = next_slot(r_head);
                            n_occ                 = r_occ - 1'b1;
                        end
                    end
                    OP_COUNT: begin
                        n_res.window_count = WCNT_W'(scan_count);
                    end
                    default: begin
                        n_res = '0;
                    end
                endcase
            end
            ST_RESULT: begin
                if (!r_out_vld || o_result.ready) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                end
            end
            default: begin
                n_rd_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_occ     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_cap     <= CAP_RESET;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_occ     <= n_occ;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
            r_cap     <= n_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_k         <= n_k;
        r_scan_addr <= n_scan_addr;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    dpfifo_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    dpfifo_scan #(
        .DEPTH (DEPTH)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_key   (r_item),
        .i_entry (rd_data),
        .o_dup   (scan_dup),
        .o_count (scan_count)
    );

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= DEPTH_OCC)
        else $error("occupancy exceeds the store size");

    a_ptr_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == r_tail) |-> ((r_occ == '0) || (r_occ == DEPTH_OCC)))
        else $error("head and tail meet with a partly filled queue");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_k <= r_occ))
        else $error("scan ran past the held records");

    a_fwd_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DECIDE) && (r_item.opcode == OP_FWD) && (r_occ != '0))
        |=> (r_occ == $past(r_occ) - 1'b1))
        else $error("forward did not remove exactly one record");
endmodule

### tb/dpfifo_checker.sv
`timescale 1ns / 1ps
module dpfifo_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    dpfifo_cfg_if i_cfg,
    dpfifo_in_if  i_item,
    dpfifo_out_if i_result,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_refusals,
    output int    o_evictions
);
    import dpfifo_pkg::*;

    localparam int IDX_W = $clog2(DEPTH_DEF);

    t_entry           held [DEPTH_DEF];
    logic [IDX_W-1:0] oldest_slot;
    logic [IDX_W-1:0] free_slot;
    logic [CAP_W-1:0] held_count;
    logic [CAP_W-1:0] capacity;
    t_out_item        expected_results [$];
    int               mismatches = 0;
    int               refusals = 0;
    int               evictions = 0;

    // Updates the packet store for one command and returns the beat it must produce.
    function automatic t_out_item apply_command(t_in_item cmd);
        t_out_item        res;
        logic             dup;
        logic [IDX_W-1:0] slot;
        logic [CAP_W-1:0] limit;
        int               hits;
        res   = '0;
        dup   = 1'b0;
        hits  = 0;
        limit = (capacity == '0) ? CAP_W'(1) :
                (capacity > CAP_W'(DEPTH_DEF)) ? CAP_W'(DEPTH_DEF) : capacity;
        case (cmd.opcode)
            OP_ADD: begin
                for (int k = 0; k < held_count; k++) begin
                    slot = oldest_slot + IDX_W'(k);
                    if (held[slot] == {cmd.source, cmd.destination, cmd.timestamp})
                        dup = 1'b1;
                end
                if (dup) begin
                    refusals++;
                end else begin
                    // The duplicate scan runs before the oldest record is dropped.
                    if (held_count >= limit && held_count != '0) begin
                        oldest_slot++;
                        held_count--;
                        evictions++;
                    end
                    held[free_slot] = {cmd.source, cmd.destination, cmd.timestamp};
                    free_slot++;
                    held_count++;
                    res.accepted = 1'b1;
                end
            end
            OP_FWD: begin
                if (held_count != '0) begin
                    res.packet_valid    = 1'b1;
                    res.out_source      = held[oldest_slot].source;
                    res.out_destination = held[oldest_slot].destination;
                    res.out_timestamp   = held[oldest_slot].timestamp;
                    oldest_slot++;
                    held_count--;
                end
            end
            OP_COUNT: begin
                for (int k = 0; k < held_count; k++) begin
                    slot = oldest_slot + IDX_W'(k);
                    if (held[slot].destination == cmd.destination &&
                        held[slot].timestamp >= cmd.start_time &&
                        held[slot].timestamp <= cmd.end_time)
                        hits++;
                end
                res.window_count = WCNT_W'(hits);
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, name,
                         want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            oldest_slot = '0;
            free_slot   = '0;
            held_count  = '0;
            capacity    = CAP_RESET;
            expected_results.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                capacity = i_cfg.data;
            if (i_result.valid && i_result.ready) begin
                got = i_result.data;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat 0x%0h with nothing outstanding",
                                 $realtime, got);
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    check_field("accepted", 32'(want.accepted), 32'(got.accepted));
                    check_field("packet_valid", 32'(want.packet_valid),
                                32'(got.packet_valid));
                    check_field("out_source", 32'(want.out_source), 32'(got.out_source));
                    check_field("out_destination", 32'(want.out_destination),
                                32'(got.out_destination));
                    check_field("out_timestamp", 32'(want.out_timestamp),
                                32'(got.out_timestamp));
                    check_field("window_count", 32'(want.window_count),
                                32'(got.window_count));
                end
            end
            if (i_item.valid && i_item.ready)
                expected_results.insert(expected_results.size(),
                                        apply_command(i_item.data));
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_results.size();
        o_refusals   <= refusals;
        o_evictions  <= evictions;
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import dpfifo_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int              PHASES = 10;
    localparam int              PHASE_CMDS = 85;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic quiet = 1'b0;

    int fail_count;
    int pending;
    int refusals;
    int evictions;
    int command_total = 0;

    logic [CAP_W-1:0] cap_plan [PHASES];
    t_entry           recent_records [$];
    logic [TS_W-1:0]  ts_clock = '0;

    dpfifo_cfg_if cfg_bus ();
    dpfifo_in_if  item_bus ();
    dpfifo_out_if result_bus ();

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    dedup_packet_fifo_with_window_count_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_bus),
        .i_item   (item_bus),
        .o_result (result_bus)
    );

    dpfifo_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_bus),
        .i_item       (item_bus),
        .i_result     (result_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_refusals   (refusals),
        .o_evictions  (evictions)
    );

    function automatic t_in_item make_cmd(logic [OP_W-1:0] op, logic [SRC_W-1:0] src,
                                          logic [DST_W-1:0] dst, logic [TS_W-1:0] ts,
                                          logic [TS_W-1:0] t0, logic [TS_W-1:0] t1);
        t_in_item cmd;
        cmd.opcode      = op;
        cmd.source      = src;
        cmd.destination = dst;
        cmd.timestamp   = ts;
        cmd.start_time  = t0;
        cmd.end_time    = t1;
        return cmd;
    endfunction

    // Mostly adds and queries around records seen recently, so duplicates and
    // nonzero window counts are common; the rest is full-range noise.
    function automatic t_in_item random_command();
        t_in_item cmd;
        t_entry   rec;
        int       roll;
        int       kind;
        cmd = make_cmd(OP_ADD, SRC_W'($urandom), DST_W'($urandom), TS_W'($urandom),
                       TS_W'($urandom), TS_W'($urandom));
        roll = $urandom_range(0, 99);
        kind = $urandom_range(0, 9);
        if (recent_records.size() != 0)
            rec = recent_records[$urandom_range(0, recent_records.size() - 1)];
        else
            rec = '0;
        if (roll < 45) begin
            if (kind < 3 && recent_records.size() != 0) begin
                cmd.source      = rec.source;
                cmd.destination = rec.destination;
                cmd.timestamp   = rec.timestamp;
            end else if (kind < 7) begin
                cmd.source      = SRC_W'($urandom_range(0, 7));
                cmd.destination = DST_W'($urandom_range(0, 3));
                cmd.timestamp   = ts_clock;
                ts_clock        = ts_clock + TS_W'($urandom_range(0, 3));
            end
            recent_records.insert(recent_records.size(),
                                  {cmd.source, cmd.destination, cmd.timestamp});
            if (recent_records.size() > 32)
                recent_records.delete(0);
        end else if (roll < 70) begin
            cmd.opcode = OP_FWD;
        end else if (roll < 95) begin
            cmd.opcode = OP_COUNT;
            if (kind < 6 && recent_records.size() != 0) begin
                cmd.destination = rec.destination;
                cmd.start_time  = rec.timestamp - TS_W'($urandom_range(0, 4));
                cmd.end_time    = rec.timestamp + TS_W'($urandom_range(0, 4));
            end else if (kind < 8) begin
                cmd.destination = DST_W'($urandom_range(0, 3));
                cmd.start_time  = '0;
                cmd.end_time    = '1;
            end else if (kind == 8) begin
                cmd.destination = rec.destination;
                cmd.start_time  = rec.timestamp + TS_W'(1);
                cmd.end_time    = rec.timestamp;
            end
        end else begin
            cmd.opcode = OP_UNUSED;
        end
        return cmd;
    endfunction

    // Leaves valid high across back-to-back beats; it only drops for a gap.
    task automatic send(t_in_item cmd);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_bus.valid <= 1'b1;
        item_bus.data  <= cmd;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
        command_total++;
    endtask

    task automatic settle();
        item_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    initial begin : result_stall
        int hold;
        result_bus.ready = 1'b0;
        forever begin
            hold = quiet ? 0 : $urandom_range(0, 6);
            if (hold != 0) begin
                result_bus.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            result_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!result_bus.valid) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        item_bus.valid = 1'b0;
        item_bus.data  = '0;
        cfg_bus.valid  = 1'b0;
        cfg_bus.data   = '0;
        cap_plan = '{9'd256, 9'd3, 9'd0, 9'd511, 9'd1, 9'd40, 9'd300, 9'd2, 9'd255, 9'd256};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty queue, all-ones and all-zero records, a refused duplicate,
        // inverted and single-point windows, and the unused opcode.
        send(make_cmd(OP_FWD, '1, '1, '1, '1, '1));
        send(make_cmd(OP_COUNT, '0, '0, '0, '0, '1));
        send(make_cmd(OP_ADD, '1, '1, '1, '0, '0));
        send(make_cmd(OP_ADD, '1, '1, '1, '1, '1));
        send(make_cmd(OP_ADD, '0, '0, '0, '1, '1));
        send(make_cmd(OP_ADD, 20'd5, '1, 30'd5, '0, '0));
        send(make_cmd(OP_COUNT, '0, '1, '0, '0, '1));
        send(make_cmd(OP_COUNT, '0, '1, '0, 30'd10, 30'd5));
        send(make_cmd(OP_COUNT, '0, '1, '0, 30'd5, 30'd5));
        send(make_cmd(OP_COUNT, '1, '0, '1, '0, '0));
        send(make_cmd(OP_UNUSED, SRC_W'($urandom), DST_W'($urandom), TS_W'($urandom),
                      TS_W'($urandom), TS_W'($urandom)));
        send(make_cmd(OP_FWD, '0, '0, '0, '0, '0));
        settle();

        // Re-adding the record next in line for eviction must still be refused.
        write_capacity(9'd2);
        send(make_cmd(OP_ADD, '0, '0, '0, '0, '0));
        send(make_cmd(OP_ADD, 20'd7, 20'd8, 30'd9, '0, '0));
        settle();

        // Zero capacity acts as one while two records are already held.
        write_capacity(9'd0);
        send(make_cmd(OP_ADD, 20'd1, 20'd2, 30'd3, '0, '0));
        send(make_cmd(OP_COUNT, '0, 20'd8, '0, '0, '1));
        send(make_cmd(OP_FWD, '0, '0, '0, '0, '0));
        send(make_cmd(OP_FWD, '0, '0, '0, '0, '0));
        send(make_cmd(OP_FWD, '0, '0, '0, '0, '0));
        settle();

        ts_clock = TS_W'($urandom);
        for (int p = 0; p < PHASES; p++) begin
            write_capacity(cap_plan[p]);
            quiet = (p % 4 == 2);
            for (int n = 0; n < PHASE_CMDS; n++) begin
                if (p == 5 && n == PHASE_CMDS / 2)
                    settle();
                send(random_command());
            end
            settle();
        end
        quiet = 1'b0;

        $display("%0d commands over %0d capacity settings, including 0, 1, 256 and 511.",
                 command_total, PHASES + 3);
        $display("%0d duplicate adds refused, %0d oldest records evicted on add.",
                 refusals, evictions);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("Timed out with %0d results outstanding.", pending);
        $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/dpfifo_pkg.sv
rtl/dpfifo_if.sv
rtl/dpfifo_ram.sv
rtl/dpfifo_scan.sv
rtl/dedup_packet_fifo_with_window_count_unit.sv
tb/dpfifo_checker.sv
tb/testbench.sv
